[design/table_linear_interpolator_assert.svh]
// assertion macros for the table interpolator checker
// no dependencies
`ifndef TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
// implication checked on every clock, quiet in reset
`define TLI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TLI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

[design/tli_pkg.sv]
// shared types and constants for the table interpolator
// no dependencies
package tli_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned SlotW = 8;
  localparam int unsigned CountW = 9;
  localparam logic ReqWrite = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [SlotW-1:0]  entry_index;
    logic [DataW-1:0]  entry_x;
    logic [DataW-1:0]  entry_f;
    logic [DataW-1:0]  entry_df;
    logic [DataW-1:0]  query_x;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] interp_f;
    logic [DataW-1:0] interp_df;
    logic [SlotW-1:0] upper_slot;
    logic             below_range;
    logic             above_range;
    logic             saturated;
    logic             is_write_ack;
  } rsp_t;

  // queue entry handed from front to back
  typedef struct packed {
    logic             is_write;
    logic [SlotW-1:0] entry_index;
    logic [DataW-1:0] entry_x;
    logic [DataW-1:0] entry_f;
    logic [DataW-1:0] entry_df;
    logic [DataW-1:0] query_x;
  } cmd_t;
endpackage

[design/tli_req_if.sv]
// request and response channel interfaces
// depends on tli_pkg
interface tli_req_if;
  logic valid;
  logic ready;
  tli_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tli_rsp_if;
  logic valid;
  logic ready;
  tli_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tli_cfg_if;
  logic valid;
  logic ready;
  logic [8:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/tli_front.sv]
// front part: accepts transactions and queues them for the back part
// depends on tli_pkg
module tli_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  tli_pkg::req_t req_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output tli_pkg::cmd_t cmd_o
);
  import tli_pkg::*;
  // two-entry queue
  cmd_t        mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push, pop;
  cmd_t        cmd;

  assign req_ready_o = (cnt_q != 2'd2);
  assign push = req_valid_i && req_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_o = mem_q[rp_q];

  always_comb begin
    cmd.is_write    = (req_i.req_type == ReqWrite);
    cmd.entry_index = req_i.entry_index;
    cmd.entry_x     = req_i.entry_x;
    cmd.entry_f     = req_i.entry_f;
    cmd.entry_df    = req_i.entry_df;
    cmd.query_x     = req_i.query_x;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[design/tli_div.sv]
// restoring divider, one quotient bit a cycle, unsigned
// depends on tli_pkg
module tli_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 33
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  import tli_pkg::*;
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;

  assign quo_o = quo_q;
  assign done_o = busy_q && (cnt_q == CntW'(0));

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == CntW'(0)) begin
        busy_d = 1'b0;
      end else begin
        if (trial >= {1'b0, den_q}) begin
          rem_d = trial - {1'b0, den_q};
          quo_d = {quo_q[NumW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[NumW-2:0], 1'b0};
        end
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) den_q <= den_i;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      busy_q <= busy_d;
    end
  end
endmodule

[design/tli_back.sv]
// back part: table memories, linear search, interpolation and output register
// depends on tli_pkg, tli_div
module tli_back #(
  parameter int unsigned TableDepth = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [tli_pkg::CountW-1:0] point_count_i,
  input  logic                   cmd_valid_i,
  output logic                   cmd_ready_o,
  input  tli_pkg::cmd_t          cmd_i,
  output logic                   rsp_valid_o,
  input  logic                   rsp_ready_i,
  output tli_pkg::rsp_t          rsp_o
);
  import tli_pkg::*;
  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned MaxN = (TableDepth < 256) ? TableDepth : 256;
  localparam int unsigned NW = $clog2(MaxN + 1);
  // wide enough for y0 plus a quotient just under 2^34
  localparam int unsigned ResW = DataW + 4;
  localparam logic signed [ResW-1:0] SatMag = ResW'(1) << 34;
  localparam logic signed [ResW-1:0] MaxS = ResW'(32'sh7fffffff);
  localparam logic signed [ResW-1:0] MinS = ResW'(32'sh80000000);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StScan = 4'd1;
  localparam logic [3:0] StScanChk = 4'd2;
  localparam logic [3:0] StRdLo = 4'd3;
  localparam logic [3:0] StRdHi = 4'd4;
  localparam logic [3:0] StRdBase = 4'd5;
  localparam logic [3:0] StDiff = 4'd6;
  localparam logic [3:0] StMulA = 4'd7;
  localparam logic [3:0] StMulB = 4'd8;
  localparam logic [3:0] StDivF = 4'd9;
  localparam logic [3:0] StDivD = 4'd10;
  localparam logic [3:0] StOut = 4'd11;
  localparam logic [3:0] StWr = 4'd12;

  logic [DataW-1:0] mx [TableDepth];
  logic [DataW-1:0] mf [TableDepth];
  logic [DataW-1:0] md [TableDepth];
  logic [DataW-1:0] rx_q, rf_q, rd_q;
  logic [AddrW-1:0] raddr;
  logic             wen;

  logic [3:0]       st_q;
  cmd_t             cmd_q;
  logic [NW-1:0]    n_q, i_q;
  logic [NW-1:0]    nclamp;
  logic [SlotW-1:0] upper_q, base_q;
  logic             below_q, above_q;
  logic signed [DataW:0] xlo_q, xhi_q;
  logic signed [DataW-1:0] flo_q, fhi_q, dlo_q, dhi_q, fb_q, db_q;
  logic signed [DataW:0] dx_q, dq_q, dyf_q, dyd_q;
  logic [2*DataW+1:0] prod_q;
  logic               negf_q, negd_q;
  logic signed [ResW-1:0] rf_res_q, rd_res_q;
  logic               satf, satd;
  rsp_t               out_q;
  logic               out_v_q;
  logic               out_load;

  logic               dstart;
  logic [2*DataW+1:0] dnum;
  logic               ddone;
  logic [2*DataW+1:0] dquo;

  tli_div #(.NumW(2*DataW+2), .DenW(DataW+1)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum),
    .den_i(dx_q[DataW] ? (DataW+1)'(0) - dx_q[DataW:0] : dx_q[DataW:0]),
    .done_o(ddone), .quo_o(dquo)
  );

  function automatic logic [DataW:0] mag(input logic signed [DataW:0] v);
    return v[DataW] ? (DataW+1)'(0) - v : v;
  endfunction

  // saturating add or subtract of a quotient onto the base value
  function automatic logic signed [ResW-1:0] lerp(input logic signed [DataW-1:0] y0,
      input logic [2*DataW+1:0] q, input logic neg);
    logic signed [ResW-1:0] r;
    if (q >= (64'd1 << 34)) begin
      r = neg ? -SatMag : SatMag;
    end else begin
      r = neg ? ResW'(y0) - ResW'({1'b0, q[33:0]})
              : ResW'(y0) + ResW'({1'b0, q[33:0]});
    end
    return r;
  endfunction

  function automatic logic [DataW-1:0] clip(input logic signed [ResW-1:0] r);
    if (r > MaxS) return MaxS[DataW-1:0];
    if (r < MinS) return MinS[DataW-1:0];
    return r[DataW-1:0];
  endfunction

  assign nclamp = (point_count_i < 9'd2) ? NW'(2) :
                  ((point_count_i > 9'(MaxN)) ? NW'(MaxN) : NW'(point_count_i));
  assign cmd_ready_o = (st_q == StIdle);
  assign wen = (st_q == StWr) && (32'(cmd_q.entry_index) < TableDepth);

  always_comb begin
    raddr = AddrW'(i_q);
    case (st_q)
      StRdLo:   raddr = AddrW'(upper_q - 8'd1);
      StRdHi:   raddr = AddrW'(upper_q);
      StRdBase: raddr = AddrW'(base_q);
      default:  raddr = AddrW'(i_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mx[AddrW'(cmd_q.entry_index)] <= cmd_q.entry_x;
      mf[AddrW'(cmd_q.entry_index)] <= cmd_q.entry_f;
      md[AddrW'(cmd_q.entry_index)] <= cmd_q.entry_df;
    end
    rx_q <= mx[raddr];
    rf_q <= mf[raddr];
    rd_q <= md[raddr];
  end

  assign satf = (rf_res_q > MaxS) || (rf_res_q < MinS);
  assign satd = (rd_res_q > MaxS) || (rd_res_q < MinS);
  assign dstart = (st_q == StMulB) || ((st_q == StDivF) && ddone);
  assign dnum = prod_q;
  assign rsp_valid_o = out_v_q;
  assign rsp_o = out_q;
  assign out_load = ((st_q == StOut) || (st_q == StWr)) && (!out_v_q || rsp_ready_i);

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: if (cmd_valid_i) cmd_q <= cmd_i;
      StScanChk: begin
        if ($signed(rx_q) > $signed(cmd_q.query_x) || i_q == n_q - NW'(1)) begin
          if ($signed(rx_q) > $signed(cmd_q.query_x)) begin
            below_q <= (i_q == '0);
            above_q <= 1'b0;
            upper_q <= (i_q == '0) ? 8'd1 : 8'(i_q);
            base_q  <= (i_q == '0) ? 8'd0 : 8'(i_q - NW'(1));
          end else begin
            below_q <= 1'b0;
            above_q <= 1'b1;
            upper_q <= 8'(n_q - NW'(1));
            base_q  <= 8'(n_q - NW'(1));
          end
        end
      end
      StRdHi: begin
        xlo_q <= (DataW+1)'($signed(rx_q));
        flo_q <= rf_q;
        dlo_q <= rd_q;
      end
      StRdBase: begin
        xhi_q <= (DataW+1)'($signed(rx_q));
        fhi_q <= rf_q;
        dhi_q <= rd_q;
      end
      StDiff: begin
        fb_q  <= rf_q;
        db_q  <= rd_q;
        dx_q  <= xhi_q - xlo_q;
        dq_q  <= (DataW+1)'($signed(cmd_q.query_x)) - (DataW+1)'($signed(rx_q));
        dyf_q <= (DataW+1)'(fhi_q) - (DataW+1)'(flo_q);
        dyd_q <= (DataW+1)'(dhi_q) - (DataW+1)'(dlo_q);
      end
      // f product first, the divider takes it as the df product replaces it
      StMulA: begin
        prod_q <= {{(DataW+1){1'b0}}, mag(dyf_q)} * {{(DataW+1){1'b0}}, mag(dq_q)};
      end
      StMulB: begin
        prod_q <= {{(DataW+1){1'b0}}, mag(dyd_q)} * {{(DataW+1){1'b0}}, mag(dq_q)};
        negf_q <= (dyf_q[DataW] ^ dq_q[DataW]) ^ dx_q[DataW];
        negd_q <= (dyd_q[DataW] ^ dq_q[DataW]) ^ dx_q[DataW];
      end
      StDivF: begin
        if (ddone) begin
          rf_res_q <= (dx_q == '0) ? ResW'(fb_q) : lerp(fb_q, dquo, negf_q);
        end
      end
      StDivD: begin
        if (ddone) begin
          rd_res_q <= (dx_q == '0) ? ResW'(db_q) : lerp(db_q, dquo, negd_q);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      if (st_q == StOut) begin
        out_q <= '{interp_f: clip(rf_res_q), interp_df: clip(rd_res_q),
                   upper_slot: upper_q, below_range: below_q, above_range: above_q,
                   saturated: satf || satd, is_write_ack: 1'b0};
      end else begin
        out_q <= '{is_write_ack: 1'b1, default: '0};
      end
    end
  end

  // StDivF started the second divide right after done; the state waits on it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      out_v_q <= 1'b0;
      n_q <= NW'(2);
      i_q <= '0;
    end else begin
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_v_q <= 1'b0;
      end
      case (st_q)
        StIdle: if (cmd_valid_i) begin
          i_q <= '0;
          n_q <= nclamp;
          st_q <= (cmd_i.is_write) ? StWr : StScan;
        end
        StScan: st_q <= StScanChk;
        StScanChk: begin
          if ($signed(rx_q) > $signed(cmd_q.query_x) || i_q == n_q - NW'(1)) begin
            st_q <= StRdLo;
          end else begin
            i_q <= i_q + NW'(1);
            st_q <= StScan;
          end
        end
        StRdLo: st_q <= StRdHi;
        StRdHi: st_q <= StRdBase;
        StRdBase: st_q <= StDiff;
        StDiff: st_q <= StMulA;
        StMulA: st_q <= StMulB;
        StMulB: st_q <= StDivF;
        StDivF: if (ddone) st_q <= StDivD;
        StDivD: if (ddone && !dstart) st_q <= StOut;
        StOut, StWr: if (out_load) begin
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

[design/table_linear_interpolator.sv]
// a write acknowledgement passes from the idle state through the write state into the
// output register; a query result passes a linear search that compares table entries
// in turn, then two serial divisions, one for the value and one for the derivative
// the back part works on one transaction at a time; a two-deep queue
// in front takes further transactions while it works
// reset: point_count returns to 2, queue and output register empty; table undefined
module table_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  tli_cfg_if.sink   cfg,
  tli_req_if.sink   req,
  tli_rsp_if.source rsp
);
  import tli_pkg::*;
  // point count register, to be written while idle; the block itself does not enforce this
  logic [CountW-1:0] point_count_q;
  // front to back queue handshake
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= CountW'(2);
    end else if (cfg.valid) begin
      point_count_q <= cfg.data;
    end
  end

  // front: accepts transactions into the queue
  tli_front u_front (
    .clk_i, .rst_ni,
    .req_valid_i(req.valid), .req_ready_o(req.ready), .req_i(req.data),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  // back: table, search, interpolation, output register
  tli_back #(.TableDepth(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni, .point_count_i(point_count_q),
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .rsp_valid_o(rsp.valid), .rsp_ready_i(rsp.ready), .rsp_o(rsp.data)
  );
endmodule

[design/tli_checker.sv]
// port-level assertions for the table interpolator, with bind
// depends on the assertion macro header
`include "table_linear_interpolator_assert.svh"
module tli_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic ack,
  input logic below,
  input logic above,
  input logic [7:0] slot
);
  `TLI_ASSERT_NXT(a_hold, clk_i, rst_ni, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
  `TLI_ASSERT_IMP(a_flags, clk_i, rst_ni, rsp_valid, !(below && above), "both range flags")
  `TLI_ASSERT_IMP(a_below, clk_i, rst_ni, rsp_valid && below, slot == 8'd1, "below slot")
  `TLI_ASSERT_IMP(a_ack, clk_i, rst_ni, rsp_valid && ack, slot == 8'd0, "ack slot")
endmodule

bind table_linear_interpolator tli_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .ack(rsp.data.is_write_ack), .below(rsp.data.below_range),
  .above(rsp.data.above_range), .slot(rsp.data.upper_slot)
);
